// ===== rtl/go_back_n_sender_core_macros.svh =====
// ----------------------------------------------------------------------------
// Go-Back-N sender assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_CORE_MACROS_SVH
`define GO_BACK_N_SENDER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge out of reset
`define GBN_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
    else $error("gbn: invariant violated");

// consequent must hold in the same cycle as the antecedent
`define GBN_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("gbn: implication violated");

`else

`define GBN_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define GBN_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants of the Go-Back-N sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int MAX_WINDOW_DEF = 8;
  localparam int SEQ_BITS_DEF   = 8;

  localparam int WIN_W  = 4;
  localparam int TMO_W  = 24;
  localparam int DATA_W = 32;
  localparam int FLT_W  = 4;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [WIN_W-1:0] WIN_RST = 4'd8;
  localparam logic [TMO_W-1:0] TMO_RST = 24'd1000;
  localparam logic [TMO_W-1:0] CNT_MAX = 24'hFFFFFF;

  // register index = paddr[2]
  typedef enum logic {
    REG_WINDOW  = 1'b0,
    REG_TIMEOUT = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ACK   = 2'd1,
    OP_OFFER = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_RS_READ = 3'b010,
    ST_RS_WAIT = 3'b100
  } state_e;

  // output beat flags, has_packet in bit 0
  typedef struct packed {
    logic offer_rejected;
    logic is_resend;
    logic has_packet;
  } beat_flags_t;

endpackage

// ===== rtl/go_back_n_sender_core.sv =====
// ----------------------------------------------------------------------------
// go_back_n_sender_core
// Go-Back-N ARQ sender with window buffer, cumulative ACK and timeout resend.
// ----------------------------------------------------------------------------
// Offers, ACKs and timer ticks arrive as beats on the slave stream (tuser is
// the op code) and are taken at one beat per cycle while the output register
// is free. Each gives one result beat, except a tick that hits the timeout
// with packets outstanding: that tick gives one beat per outstanding packet,
// oldest first, with tlast on the newest; each packet is read from the window
// buffer, then loaded into the output register. No input is taken until the
// last resend beat is in the output register. The window buffer is a ring of
// MAX_WINDOW words addressed from a head pointer that moves on each ACK, so no
// data is copied. Its contents are undefined after reset and need no clearing
// pass; only written entries are ever read. The user must set window and
// timeout over APB (0x0, 0x4) only while idle; the block does not enforce it.
`include "go_back_n_sender_core_macros.svh"

module go_back_n_sender_core #(
  parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF,
  parameter int SEQ_BITS   = gbn_pkg::SEQ_BITS_DEF,
  parameter int IN_DW      = ((SEQ_BITS + gbn_pkg::DATA_W + 7) / 8) * 8,
  parameter int OUT_DW     = ((SEQ_BITS + gbn_pkg::DATA_W + gbn_pkg::FLT_W + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // slave stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [IN_DW-1:0]             s_axis_tdata,  // ack_seq, data_word, zero pad
  input  logic [1:0]                   s_axis_tuser,  // op
  // master stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [OUT_DW-1:0]            m_axis_tdata,  // pkt_seq, pkt_data, in_flight, pad
  output logic [2:0]                   m_axis_tuser,  // has_packet, is_resend, offer_rejected
  output logic                         m_axis_tlast,  // last
  // APB configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gbn_pkg::APB_AW-1:0]   paddr,
  input  logic [gbn_pkg::APB_DW-1:0]   pwdata,
  output logic [gbn_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int IDX_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W     = $clog2(2 * MAX_WINDOW);
  localparam int WIN_EFF_W = $clog2(MAX_WINDOW + 1);
  localparam int OUT_PAD   = OUT_DW - SEQ_BITS - gbn_pkg::DATA_W - gbn_pkg::FLT_W;
  // window never spans the whole sequence space
  localparam int SEQ_CAP   = (1 << SEQ_BITS) - 1;
  localparam int WIN_CAP   = (MAX_WINDOW < SEQ_CAP) ? MAX_WINDOW : SEQ_CAP;

  // ---------------------------------------------------------------- config
  logic [WIN_EFF_W-1:0]       win_eff;
  logic [gbn_pkg::TMO_W-1:0]  limit;

  gbn_cfg #(
    .MAX_WINDOW (WIN_CAP),
    .WIN_EFF_W  (WIN_EFF_W)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .win_eff_o (win_eff),
    .limit_o   (limit)
  );

  // ---------------------------------------------------------------- state
  gbn_pkg::state_e            state_q, state_d;
  logic [SEQ_BITS-1:0]        base_q, base_d;
  logic [SEQ_BITS-1:0]        next_q, next_d;
  logic [IDX_W-1:0]           head_q, head_d;
  logic                       tact_q, tact_d;
  logic [gbn_pkg::TMO_W-1:0]  tcnt_q, tcnt_d;
  logic [SEQ_BITS-1:0]        k_q, k_d;     // resend index

  // output register
  logic                       m_valid_q, m_valid_d;
  gbn_pkg::beat_flags_t       m_flags_q, m_flags_d;
  logic [SEQ_BITS-1:0]        m_seq_q, m_seq_d;
  logic [gbn_pkg::DATA_W-1:0] m_data_q, m_data_d;
  logic [gbn_pkg::FLT_W-1:0]  m_flt_q, m_flt_d;
  logic                       m_last_q, m_last_d;
  logic                       out_load;
  logic                       out_free;

  // input fields
  gbn_pkg::op_e               in_op;
  logic [SEQ_BITS-1:0]        in_ack;
  logic [gbn_pkg::DATA_W-1:0] in_word;
  logic                       in_accept;

  // buffer port
  logic                       mem_we, mem_re;
  logic [IDX_W-1:0]           mem_waddr, mem_raddr;
  logic [gbn_pkg::DATA_W-1:0] mem_rdata;

  // datapath helpers
  logic [SEQ_BITS-1:0]        n_out;    // outstanding packets
  logic [SEQ_BITS-1:0]        ack_off;
  logic [SEQ_BITS-1:0]        drop;
  logic [SUM_W-1:0]           wr_sum, ack_sum, rd_sum;
  logic [IDX_W-1:0]           ack_head;
  logic [gbn_pkg::TMO_W-1:0]  cnt_inc;
  logic                       rs_last;

  assign in_op     = gbn_pkg::op_e'(s_axis_tuser);
  assign in_ack    = s_axis_tdata[SEQ_BITS-1:0];
  assign in_word   = s_axis_tdata[SEQ_BITS +: gbn_pkg::DATA_W];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == gbn_pkg::ST_IDLE) && out_free;

  assign n_out   = next_q - base_q;
  assign ack_off = in_ack - base_q;
  assign drop    = ack_off + SEQ_BITS'(1);
  assign cnt_inc = (tcnt_q != gbn_pkg::CNT_MAX) ? tcnt_q + gbn_pkg::TMO_W'(1) : tcnt_q;
  assign rs_last = (k_q + SEQ_BITS'(1)) == n_out;

  // ring addressing: head + offset, wrapped once at MAX_WINDOW
  assign wr_sum  = SUM_W'(head_q) + SUM_W'(n_out);
  assign ack_sum = SUM_W'(head_q) + SUM_W'(drop);
  assign rd_sum  = SUM_W'(head_q) + SUM_W'(k_q);

  assign mem_waddr = (wr_sum >= SUM_W'(MAX_WINDOW)) ?
                     IDX_W'(wr_sum - SUM_W'(MAX_WINDOW)) : IDX_W'(wr_sum);
  assign ack_head  = (ack_sum >= SUM_W'(MAX_WINDOW)) ?
                     IDX_W'(ack_sum - SUM_W'(MAX_WINDOW)) : IDX_W'(ack_sum);
  assign mem_raddr = (rd_sum >= SUM_W'(MAX_WINDOW)) ?
                     IDX_W'(rd_sum - SUM_W'(MAX_WINDOW)) : IDX_W'(rd_sum);

  gbn_buf #(
    .DEPTH  (MAX_WINDOW),
    .ADDR_W (IDX_W)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_word),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d   = state_q;
    base_d    = base_q;
    next_d    = next_q;
    head_d    = head_q;
    tact_d    = tact_q;
    tcnt_d    = tcnt_q;
    k_d       = k_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    out_load  = 1'b0;
    m_flags_d = '0;
    m_seq_d   = '0;
    m_data_d  = '0;
    m_last_d  = 1'b1;
    m_flt_d   = m_flt_q;

    unique case (state_q)
      gbn_pkg::ST_IDLE: begin
        if (in_accept) begin
          out_load = 1'b1;
          case (in_op)
            gbn_pkg::OP_OFFER: begin
              if (32'(n_out) >= 32'(win_eff)) begin
                m_flags_d.offer_rejected = 1'b1;
              end else begin
                mem_we = 1'b1;
                if (n_out == '0) begin
                  tact_d = 1'b1;
                  tcnt_d = '0;
                end
                next_d               = next_q + SEQ_BITS'(1);
                m_flags_d.has_packet = 1'b1;
                m_seq_d              = next_q;
                m_data_d             = in_word;
              end
            end
            gbn_pkg::OP_ACK: begin
              // cumulative ACK inside the outstanding range slides the base
              if (ack_off < n_out) begin
                base_d = base_q + drop;
                head_d = ack_head;
                tact_d = (drop != n_out);
                tcnt_d = '0;
              end
            end
            gbn_pkg::OP_TICK: begin
              if (tact_q) begin
                if (cnt_inc >= limit) begin
                  tcnt_d = '0;
                  if (n_out != '0) begin
                    // resend beats replace this tick's single result
                    out_load = 1'b0;
                    k_d      = '0;
                    state_d  = gbn_pkg::ST_RS_READ;
                  end
                end else begin
                  tcnt_d = cnt_inc;
                end
              end
            end
            default: ;
          endcase
        end
      end

      gbn_pkg::ST_RS_READ: begin
        mem_re  = 1'b1;
        state_d = gbn_pkg::ST_RS_WAIT;
      end

      gbn_pkg::ST_RS_WAIT: begin
        if (out_free) begin
          out_load             = 1'b1;
          m_flags_d.has_packet = 1'b1;
          m_flags_d.is_resend  = 1'b1;
          m_seq_d              = base_q + k_q;
          m_data_d             = mem_rdata;
          m_last_d             = rs_last;
          k_d                  = k_q + SEQ_BITS'(1);
          state_d              = rs_last ? gbn_pkg::ST_IDLE : gbn_pkg::ST_RS_READ;
        end
      end

      default: state_d = gbn_pkg::ST_IDLE;
    endcase

    if (out_load) begin
      m_flt_d = gbn_pkg::FLT_W'(next_d - base_d);
    end
  end

  assign m_valid_d = out_load || (m_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gbn_pkg::ST_IDLE;
      base_q    <= '0;
      next_q    <= '0;
      head_q    <= '0;
      tact_q    <= 1'b0;
      tcnt_q    <= '0;
      k_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      base_q    <= base_d;
      next_q    <= next_d;
      head_q    <= head_d;
      tact_q    <= tact_d;
      tcnt_q    <= tcnt_d;
      k_q       <= k_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_flags_q <= m_flags_d;
      m_seq_q   <= m_seq_d;
      m_data_q  <= m_data_d;
      m_flt_q   <= m_flt_d;
      m_last_q  <= m_last_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_flags_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, m_flt_q, m_data_q, m_seq_q};

  // ---------------------------------------------------------------- checks
  `GBN_ASSERT_ALWAYS(a_flight_bound, clk_i, rst_ni, 32'(n_out) <= MAX_WINDOW)
  `GBN_ASSERT_ALWAYS(a_timer_tracks_flight, clk_i, rst_ni, tact_q == (n_out != '0))
  `GBN_ASSERT_IMPLIES(a_no_take_in_resend, clk_i, rst_ni, state_q != gbn_pkg::ST_IDLE, !s_axis_tready)
  `GBN_ASSERT_IMPLIES(a_resend_last_is_newest, clk_i, rst_ni, m_valid_q && m_flags_q.is_resend && m_last_q, (m_seq_q + SEQ_BITS'(1)) == next_q)

endmodule

// ===== rtl/gbn_cfg.sv =====
// ----------------------------------------------------------------------------
// gbn_cfg
// APB register file: window size and timeout, with effective-value clamping.
// ----------------------------------------------------------------------------
module gbn_cfg #(
  parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF,
  parameter int WIN_EFF_W  = $clog2(MAX_WINDOW + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gbn_pkg::APB_AW-1:0]   paddr,
  input  logic [gbn_pkg::APB_DW-1:0]   pwdata,
  output logic [gbn_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output logic [WIN_EFF_W-1:0]         win_eff_o,
  output logic [gbn_pkg::TMO_W-1:0]    limit_o
);

  logic [gbn_pkg::WIN_W-1:0] win_q, win_d;
  logic [gbn_pkg::TMO_W-1:0] tmo_q, tmo_d;
  logic                      wr_en;
  gbn_pkg::reg_idx_e         reg_idx;
  logic [gbn_pkg::WIN_W-1:0] win_nz;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = gbn_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    win_d = win_q;
    tmo_d = tmo_q;
    if (wr_en) begin
      unique case (reg_idx)
        gbn_pkg::REG_WINDOW:  win_d = pwdata[gbn_pkg::WIN_W-1:0];
        gbn_pkg::REG_TIMEOUT: tmo_d = pwdata[gbn_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= gbn_pkg::WIN_RST;
      tmo_q <= gbn_pkg::TMO_RST;
    end else begin
      win_q <= win_d;
      tmo_q <= tmo_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      gbn_pkg::REG_WINDOW:
        prdata = {{(gbn_pkg::APB_DW-gbn_pkg::WIN_W){1'b0}}, win_q};
      gbn_pkg::REG_TIMEOUT:
        prdata = {{(gbn_pkg::APB_DW-gbn_pkg::TMO_W){1'b0}}, tmo_q};
      default: prdata = '0;
    endcase
  end

  // zero means 1; clamp to the buffer depth
  assign win_nz = (win_q == '0) ? gbn_pkg::WIN_W'(1) : win_q;

  always_comb begin
    if (32'(win_nz) > MAX_WINDOW) begin
      win_eff_o = WIN_EFF_W'(MAX_WINDOW);
    end else begin
      win_eff_o = WIN_EFF_W'(win_nz);
    end
  end

  assign limit_o = (tmo_q == '0) ? gbn_pkg::TMO_W'(1) : tmo_q;

endmodule

// ===== rtl/gbn_buf.sv =====
// ----------------------------------------------------------------------------
// gbn_buf
// Window buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gbn_buf #(
  parameter int DEPTH  = gbn_pkg::MAX_WINDOW_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [ADDR_W-1:0]            waddr_i,
  input  logic [gbn_pkg::DATA_W-1:0]   wdata_i,
  input  logic                         re_i,
  input  logic [ADDR_W-1:0]            raddr_i,
  output logic [gbn_pkg::DATA_W-1:0]   rdata_o
);

  logic [gbn_pkg::DATA_W-1:0] mem [DEPTH];
  logic [gbn_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/tb_go_back_n_sender_core.sv =====
// ----------------------------------------------------------------------------
// tb_go_back_n_sender_core
// Self-checking bench for the Go-Back-N sender core. A shadow of the sender
// state predicts every result beat. Directed beats cover the corner cases.
// Random phases then follow, each with its own window and timeout setting;
// the last one first sweeps the sequence numbers through a wrap.
// ----------------------------------------------------------------------------
module tb_go_back_n_sender_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEQ_W      = gbn_pkg::SEQ_BITS_DEF;
  localparam int FLT_W      = gbn_pkg::FLT_W;
  localparam int WIN_W      = gbn_pkg::WIN_W;
  localparam int TMO_W      = gbn_pkg::TMO_W;
  localparam int IN_DW      = ((SEQ_W + gbn_pkg::DATA_W + 7) / 8) * 8;
  localparam int OUT_DW     = ((SEQ_W + gbn_pkg::DATA_W + FLT_W + 7) / 8) * 8;
  localparam int IDLE_LIMIT = 1000;  // cycles with no beat and no APB access
  localparam int DRAIN_WAIT = 20;
  localparam int PHASE_LEN  = 36;
  localparam int WRAP_CAP   = 3000;
  localparam logic [1:0] OP_SPARE = 2'd3;  // op code with no meaning

  // one result beat as the master stream carries it
  typedef struct packed {
    logic             has_packet;
    logic [SEQ_W-1:0] pkt_seq;
    logic [31:0]      pkt_data;
    logic             is_resend;
    logic             offer_rejected;
    logic [FLT_W-1:0] in_flight;
    logic             last;
  } beat_t;

  // --------------------------------------------------------------------------
  // Shadow of the sender: window, timer and sent words, plus the queue of
  // result beats the core still owes.
  // --------------------------------------------------------------------------
  class gbn_sender_shadow;
    logic [WIN_W-1:0] window_reg  = gbn_pkg::WIN_RST;
    logic [TMO_W-1:0] timeout_reg = gbn_pkg::TMO_RST;
    logic [SEQ_W-1:0] base        = '0;
    logic [SEQ_W-1:0] next_seq    = '0;
    logic [TMO_W-1:0] tick_count  = '0;
    bit               timer_on    = 1'b0;
    bit               seq_wrapped = 1'b0;
    // words kept by sequence number; entry base+k is window slot k
    logic [31:0]      sent_words [1 << SEQ_W];
    beat_t            owed_beats [$];
    int               errors      = 0;

    function void set_reg(gbn_pkg::reg_idx_e idx, logic [31:0] value);
      if (idx == gbn_pkg::REG_WINDOW) window_reg = value[WIN_W-1:0];
      else timeout_reg = value[TMO_W-1:0];
    endfunction

    function logic [SEQ_W-1:0] in_flight();
      return next_seq - base;
    endfunction

    // zero means one, anything above the buffer depth means the full depth
    function int unsigned window_limit();
      int unsigned w;
      w = 32'(window_reg);
      if (w == 0) w = 1;
      if (w > gbn_pkg::MAX_WINDOW_DEF) w = gbn_pkg::MAX_WINDOW_DEF;
      return w;
    endfunction

    function void owe(logic hp, logic [SEQ_W-1:0] seq, logic [31:0] word,
                      logic rs, logic rej, logic lst);
      beat_t b;
      b.has_packet     = hp;
      b.pkt_seq        = seq;
      b.pkt_data       = word;
      b.is_resend      = rs;
      b.offer_rejected = rej;
      b.in_flight      = FLT_W'(in_flight());
      b.last           = lst;
      owed_beats.push_back(b);
    endfunction

    function void absorb_item(logic [1:0] op, logic [SEQ_W-1:0] ack, logic [31:0] word);
      logic [SEQ_W-1:0] n;
      logic [SEQ_W-1:0] d;
      logic [SEQ_W-1:0] seq;
      int unsigned      lim;
      n = in_flight();
      case (op)
        gbn_pkg::OP_OFFER: begin
          if (n >= window_limit()) begin
            owe(1'b0, '0, '0, 1'b0, 1'b1, 1'b1);
          end else begin
            seq = next_seq;
            sent_words[seq] = word;
            if (n == 0) begin
              timer_on   = 1'b1;
              tick_count = '0;
            end
            next_seq = next_seq + SEQ_W'(1);
            if (next_seq == 0) seq_wrapped = 1'b1;
            owe(1'b1, seq, word, 1'b0, 1'b0, 1'b1);
          end
        end
        gbn_pkg::OP_ACK: begin
          // cumulative: everything up to ack is confirmed, if ack is outstanding
          d = ack - base;
          if (d < n) begin
            base       = ack + SEQ_W'(1);
            timer_on   = (base != next_seq);
            tick_count = '0;
          end
          owe(1'b0, '0, '0, 1'b0, 1'b0, 1'b1);
        end
        gbn_pkg::OP_TICK: begin
          if (timer_on) begin
            lim = (timeout_reg == '0) ? 32'd1 : 32'(timeout_reg);
            if (tick_count != gbn_pkg::CNT_MAX) tick_count = tick_count + TMO_W'(1);
            if (32'(tick_count) >= lim) begin
              tick_count = '0;
              if (n != 0) begin
                // go back: whole window again, oldest first
                for (int k = 0; k < n; k++) begin
                  seq = base + k[SEQ_W-1:0];
                  owe(1'b1, seq, sent_words[seq], 1'b1, 1'b0, k == n - 1);
                end
                return;
              end
            end
          end
          owe(1'b0, '0, '0, 1'b0, 1'b0, 1'b1);
        end
        default: owe(1'b0, '0, '0, 1'b0, 1'b0, 1'b1);
      endcase
    endfunction

    function void flag(beat_t exp_b, beat_t got_b, string what);
      errors++;
      if (errors <= 10) begin
        $display("%0t %s", $realtime, what);
        $display("  exp pkt=%0b seq=%0d data=%h rs=%0b rej=%0b flt=%0d last=%0b",
                 exp_b.has_packet, exp_b.pkt_seq, exp_b.pkt_data, exp_b.is_resend,
                 exp_b.offer_rejected, exp_b.in_flight, exp_b.last);
        $display("  got pkt=%0b seq=%0d data=%h rs=%0b rej=%0b flt=%0d last=%0b",
                 got_b.has_packet, got_b.pkt_seq, got_b.pkt_data, got_b.is_resend,
                 got_b.offer_rejected, got_b.in_flight, got_b.last);
      end
    endfunction

    function void match_beat(beat_t got_b);
      beat_t exp_b;
      if (owed_beats.size() == 0) begin
        flag('0, got_b, "result beat with nothing owed");
        return;
      end
      exp_b = owed_beats.pop_front();
      if (got_b.has_packet     !== exp_b.has_packet     ||
          got_b.pkt_seq        !== exp_b.pkt_seq        ||
          got_b.pkt_data       !== exp_b.pkt_data       ||
          got_b.is_resend      !== exp_b.is_resend      ||
          got_b.offer_rejected !== exp_b.offer_rejected ||
          got_b.in_flight      !== exp_b.in_flight      ||
          got_b.last           !== exp_b.last)
        flag(exp_b, got_b, "result beat mismatch");
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [IN_DW-1:0]           s_axis_tdata  = '0;  // ack_seq, data_word, zero pad
  logic [1:0]                 s_axis_tuser  = '0;  // op
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [OUT_DW-1:0]          m_axis_tdata;        // pkt_seq, pkt_data, in_flight, pad
  logic [2:0]                 m_axis_tuser;        // has_packet, is_resend, offer_rejected
  logic                       m_axis_tlast;
  logic                       psel          = 1'b0;
  logic                       penable       = 1'b0;
  logic                       pwrite        = 1'b0;
  logic [gbn_pkg::APB_AW-1:0] paddr         = '0;
  logic [gbn_pkg::APB_DW-1:0] pwdata        = '0;
  logic [gbn_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  always #5 clk_i = ~clk_i;

  go_back_n_sender_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  gbn_sender_shadow shadow = new();

  bit send_calm = 1'b0;  // stretches where the sender never idles
  bit recv_calm = 1'b0;  // stretches where the receiver never stalls

  // --------------------------------------------------------------------------
  // Driving tasks. Every task starts and ends at a rising edge; all drives
  // are nonblocking, so the DUT always samples stable values.
  // --------------------------------------------------------------------------

  // Present one input beat, wait for the handshake and hand it to the shadow.
  // The gap is taken by dropping tvalid only when it is nonzero, so tvalid is
  // never lowered and raised in the same step.
  task automatic send_beat(logic [1:0] op, logic [SEQ_W-1:0] ack, logic [31:0] word);
    int gap;
    if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_DW'({word, ack});
    do @(posedge clk_i); while (!s_axis_tready);
    shadow.absorb_item(op, ack, word);
  endtask

  // Stop offering and wait until every owed result beat has come back. Each
  // item owes at least one beat, so the core is idle once the queue is empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (shadow.owed_beats.size() != 0) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready, then a return to idle
  // cycle so back-to-back writes never drive the bus twice in one step.
  task automatic reg_write(gbn_pkg::reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= gbn_pkg::APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random traffic, mostly well formed: offers while there is room, acks of
  // an outstanding number, ticks to drive the timer; a little noise on top.
  // With until_wrap the phase first fills the window and acks all of it,
  // over and over, until the sequence number has wrapped.
  task automatic random_phase(int count, bit until_wrap);
    logic [1:0]       op;
    logic [SEQ_W-1:0] ack;
    logic [SEQ_W-1:0] n;
    bit               room;
    int               r;
    int               i;
    i = 0;
    while (i < count || (until_wrap && !shadow.seq_wrapped && i < WRAP_CAP)) begin
      n    = shadow.in_flight();
      room = n < shadow.window_limit();
      if (until_wrap && !shadow.seq_wrapped) begin
        op  = room ? gbn_pkg::OP_OFFER : gbn_pkg::OP_ACK;
        ack = shadow.next_seq - SEQ_W'(1);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) op = OP_SPARE;
        else if (r < (room ? 58 : 14)) op = gbn_pkg::OP_OFFER;
        else if (r < (room ? 78 : 64)) op = gbn_pkg::OP_ACK;
        else op = gbn_pkg::OP_TICK;
        if (n != 0 && $urandom_range(0, 4) != 0)
          ack = shadow.base + SEQ_W'($urandom_range(0, n - 1));
        else
          ack = SEQ_W'($urandom);
      end
      send_beat(op, ack, $urandom);
      i++;
    end
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, checking of every accepted beat
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
      stall = recv_calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin
    beat_t                got_b;
    gbn_pkg::beat_flags_t flags;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      flags                = gbn_pkg::beat_flags_t'(m_axis_tuser);
      got_b.has_packet     = flags.has_packet;
      got_b.is_resend      = flags.is_resend;
      got_b.offer_rejected = flags.offer_rejected;
      got_b.pkt_seq        = m_axis_tdata[SEQ_W-1:0];
      got_b.pkt_data       = m_axis_tdata[SEQ_W +: 32];
      got_b.in_flight      = m_axis_tdata[SEQ_W + 32 +: FLT_W];
      got_b.last           = m_axis_tlast;
      shadow.match_beat(got_b);
    end
  end

  // watchdog: any beat or APB access counts as progress
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: window 8, timeout 1000
    send_beat(gbn_pkg::OP_TICK, '0, '0);              // tick with timer stopped
    send_beat(OP_SPARE, 8'hFF, 32'hFFFF_FFFF);        // unused op code
    send_beat(gbn_pkg::OP_ACK, 8'd0, '0);             // ack with nothing outstanding
    send_beat(gbn_pkg::OP_OFFER, '0, 32'h8000_0000);
    send_beat(gbn_pkg::OP_OFFER, '0, 32'h7FFF_FFFF);
    send_beat(gbn_pkg::OP_OFFER, '0, 32'hFFFF_FFFF);
    send_beat(gbn_pkg::OP_OFFER, '0, 32'h0000_0000);
    send_beat(gbn_pkg::OP_OFFER, '0, 32'h5555_5555);
    send_beat(gbn_pkg::OP_OFFER, '0, 32'hAAAA_AAAA);
    send_beat(gbn_pkg::OP_OFFER, '0, 32'h0000_0001);
    send_beat(gbn_pkg::OP_OFFER, '0, $urandom);
    send_beat(gbn_pkg::OP_OFFER, '0, $urandom);       // window full: refused
    send_beat(gbn_pkg::OP_ACK, 8'd200, '0);           // outside the outstanding range
    send_beat(gbn_pkg::OP_ACK, 8'd2, '0);             // slides base to 3
    repeat (5) send_beat(gbn_pkg::OP_TICK, '0, '0);   // count reaches 5
    settle();

    // timeout lowered below the running count: next tick resends seq 3..7
    reg_write(gbn_pkg::REG_TIMEOUT, 32'd3);
    send_beat(gbn_pkg::OP_TICK, '0, '0);
    send_beat(gbn_pkg::OP_ACK, 8'd255, '0);           // stale, ignored
    send_beat(gbn_pkg::OP_ACK, 8'd7, '0);             // all acked, timer stops
    settle();

    // window register zero acts as one
    reg_write(gbn_pkg::REG_WINDOW, 32'd0);
    send_beat(gbn_pkg::OP_OFFER, '0, $urandom);
    send_beat(gbn_pkg::OP_OFFER, '0, $urandom);       // refused
    settle();
    // timeout register zero acts as one: first tick resends
    reg_write(gbn_pkg::REG_TIMEOUT, 32'd0);
    send_beat(gbn_pkg::OP_TICK, '0, '0);
    send_beat(gbn_pkg::OP_ACK, shadow.next_seq - SEQ_W'(1), '0);
    settle();

    // random phases over a spread of settings, extremes included
    reg_write(gbn_pkg::REG_WINDOW, 32'd4);   reg_write(gbn_pkg::REG_TIMEOUT, 32'd5);
    random_phase(PHASE_LEN, 1'b0);
    reg_write(gbn_pkg::REG_WINDOW, 32'd15);  reg_write(gbn_pkg::REG_TIMEOUT, 32'd2);
    random_phase(PHASE_LEN, 1'b0);           // window saturates to 8
    reg_write(gbn_pkg::REG_WINDOW, 32'd1);   reg_write(gbn_pkg::REG_TIMEOUT, 32'd1);
    random_phase(PHASE_LEN, 1'b0);
    reg_write(gbn_pkg::REG_WINDOW, 32'd0);   reg_write(gbn_pkg::REG_TIMEOUT, 32'd0);
    random_phase(PHASE_LEN, 1'b0);
    reg_write(gbn_pkg::REG_WINDOW, 32'd8);   reg_write(gbn_pkg::REG_TIMEOUT, 32'hFF_FFFF);
    random_phase(PHASE_LEN, 1'b0);
    reg_write(gbn_pkg::REG_WINDOW, 32'd3);   reg_write(gbn_pkg::REG_TIMEOUT, 32'd7);
    random_phase(PHASE_LEN, 1'b0);
    reg_write(gbn_pkg::REG_WINDOW, 32'd2);   reg_write(gbn_pkg::REG_TIMEOUT, 32'd3);
    random_phase(PHASE_LEN, 1'b0);
    // last phase sweeps until the sequence number has wrapped
    reg_write(gbn_pkg::REG_WINDOW, 32'd8);   reg_write(gbn_pkg::REG_TIMEOUT, 32'd4);
    random_phase(PHASE_LEN, 1'b1);

    // let any stray beat show up before judging
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (shadow.errors == 0 && shadow.owed_beats.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
